FILE: src/wpf_pkg.sv
// shared types, codes and constants of the waypoint path follower
package wpf_pkg;

	localparam int WPF_MAX_WAYPOINTS = 64;
	localparam int WPF_CORDIC_STEPS  = 16;

	// configuration register indexes
	localparam logic [1:0] REG_PATH_LENGTH     = 2'd0;
	localparam logic [1:0] REG_ARRIVE_RADIUS   = 2'd1;
	localparam logic [1:0] REG_ANGLE_TOLERANCE = 2'd2;

	// item opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// drive commands
	localparam logic [1:0] CMD_STOP    = 2'd0;
	localparam logic [1:0] CMD_FORWARD = 2'd1;
	localparam logic [1:0] CMD_RIGHT   = 2'd2;
	localparam logic [1:0] CMD_LEFT    = 2'd3;

	// pending turn codes
	localparam logic [1:0] TURN_NONE  = 2'd0;
	localparam logic [1:0] TURN_RIGHT = 2'd1;
	localparam logic [1:0] TURN_LEFT  = 2'd2;

	localparam logic [15:0] QUARTER_TURN = 16'd16384;

	// bearing in 1/65536 degree, two full turns of bias plus half a step of rounding
	localparam int DEG_HALF      = 11796480;
	localparam int ROUND_BIAS    = 47186100;
	// floor(v / 360) as (v * RECIP_360) >> RECIP_SHIFT, exact for v below 2^28
	localparam logic [26:0] RECIP_360 = 27'd95443718;
	localparam int RECIP_SHIFT   = 35;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_DIFF  = 12'b000000000010,
		ST_SQX   = 12'b000000000100,
		ST_SQY   = 12'b000000001000,
		ST_RAD   = 12'b000000010000,
		ST_CMP   = 12'b000000100000,
		ST_WAIT  = 12'b000001000000,
		ST_ROT   = 12'b000010000000,
		ST_SCALE = 12'b000100000000,
		ST_QUO   = 12'b001000000000,
		ST_TURN  = 12'b010000000000,
		ST_CMD   = 12'b100000000000
	} wpf_state_t;

	// atan(2^-i) in degrees times 65536
	function automatic logic [21:0] atan_deg(input logic [4:0] i);
		logic [21:0] r;
		case (i)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117304;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			5'd20:   r = 22'd4;
			5'd21:   r = 22'd2;
			5'd22:   r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/wpf_ram.sv
// generic single-write, single-read ram with registered read data
module wpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/waypoint_path_follower.sv
// waypoint path follower: table of waypoints, arrival test, cordic bearing, turn choice
//
// channel   direction  handshake                   payload
// item      in         start, busy (start && !busy) opcode, waypoint_index, pos_x, pos_y,
//                                                   heading
// result    out        strobe, one cycle            drive_command, done_res, target_index
// config    in         cfg_we                       cfg_index, cfg_data
//
// a load item shows its result in the cycle after it is taken and never raises busy
// a tick with the target already at or past the path length goes straight to the command state
// a tick without arrival, or with arrival at the last waypoint, passes through the read,
//   three passes of the shared multiplier for dx^2, dy^2 and radius^2, the compare and the command
// a tick with arrival and a next waypoint goes on to read that waypoint, run the cordic loop
//   and scale the bearing, or skips both when the vehicle sits on that waypoint: the cordic
//   loop runs one rotation per cycle and the bearing scale reuses the multiplier
// strobe rises with the fall of busy; the receiver cannot stall, so nothing waits on it
// reset clears the control state and restores the register defaults; the waypoint
//   table is not cleared
module waypoint_path_follower import wpf_pkg::*; #(
	parameter int MAX_WAYPOINTS = WPF_MAX_WAYPOINTS,
	parameter int CORDIC_STEPS  = WPF_CORDIC_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [5:0]         waypoint_index,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [15:0]        heading,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	output logic               strobe,
	output logic [1:0]         drive_command,
	output logic               done_res,
	output logic [6:0]         target_index
);

	localparam int ADDR_W = $clog2(MAX_WAYPOINTS);
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int CW     = 28;   // cordic x and y
	localparam int ACC_W  = 27;   // angle accumulator, 1/65536 degree
	localparam int V_W    = 26;   // biased angle ahead of the divide by 360
	localparam int MUL_W  = 27;   // shared multiplier operands

	localparam logic signed [17:0] HALF_S = 18'sd32768;

	// control state
	wpf_state_t        state_q;
	logic              phase_q;      // 0 arrival check on current target, 1 bearing to next
	logic [STEP_W-1:0] step_q;
	logic [6:0]        plen_q;
	logic [14:0]       radius_q;
	logic [14:0]       tol_q;
	logic [6:0]        target_q;
	logic [15:0]       bearing_q;
	logic [1:0]        turn_q;
	logic [1:0]        last_cmd_q;
	logic              strobe_q;
	logic              done_q;

	// payload
	logic signed [15:0]      px_q;
	logic signed [15:0]      py_q;
	logic [15:0]             car_q;
	logic signed [16:0]      dx_q;
	logic signed [16:0]      dy_q;
	logic [32:0]             d2_q;
	logic [2*MUL_W-1:0]      prod_q;
	logic signed [CW-1:0]    x_q;
	logic signed [CW-1:0]    y_q;
	logic signed [ACC_W-1:0] acc_q;

	logic        accept;
	logic [6:0]  len_c;
	logic [31:0] slot_ext;
	logic [31:0] tgt_ext;
	logic        ram_we;
	logic [31:0] ram_rdata;

	assign accept   = start && (state_q == ST_IDLE);
	assign slot_ext = 32'(waypoint_index);
	assign tgt_ext  = 32'(target_q);
	// loads beyond the table are dropped
	assign ram_we   = accept && (opcode == OP_LOAD) && (slot_ext < 32'(MAX_WAYPOINTS));

	// path length saturates at the table depth
	assign len_c = (32'(plen_q) > 32'(MAX_WAYPOINTS)) ? 7'(MAX_WAYPOINTS) : plen_q;

	// x in the upper half, y in the lower; read address always follows the target
	wpf_ram #(
		.WIDTH(32),
		.DEPTH(MAX_WAYPOINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_ext[ADDR_W-1:0]),
		.wdata({pos_x, pos_y}),
		.raddr(tgt_ext[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// offsets from the vehicle to the waypoint just read
	logic signed [15:0] wx_s;
	logic signed [15:0] wy_s;
	logic signed [16:0] dx_c;
	logic signed [16:0] dy_c;
	logic [15:0]        dx_abs;
	logic [15:0]        dy_abs;

	assign wx_s   = ram_rdata[31:16];
	assign wy_s   = ram_rdata[15:0];
	assign dx_c   = 17'(wx_s) - 17'(px_q);
	assign dy_c   = 17'(wy_s) - 17'(py_q);
	assign dx_abs = dx_q[16] ? 16'(-dx_q) : dx_q[15:0];
	assign dy_abs = dy_q[16] ? 16'(-dy_q) : dy_q[15:0];

	// cordic start: offsets scaled by 256, left half plane folded over by half a turn
	logic signed [CW-1:0]    xe_c;
	logic signed [CW-1:0]    ye_c;
	logic signed [CW-1:0]    x_init;
	logic signed [CW-1:0]    y_init;
	logic signed [ACC_W-1:0] acc_init;
	logic                    zero_off;

	assign xe_c     = CW'(dx_c) <<< 8;
	assign ye_c     = CW'(dy_c) <<< 8;
	assign x_init   = dx_c[16] ? -xe_c : xe_c;
	assign y_init   = dx_c[16] ? -ye_c : ye_c;
	assign acc_init = dx_c[16] ? ACC_W'(DEG_HALF) : '0;
	assign zero_off = (dx_c == 17'sd0) && (dy_c == 17'sd0);

	// one rotation of the shared cordic step
	logic signed [CW-1:0]    xs_c;
	logic signed [CW-1:0]    ys_c;
	logic signed [ACC_W-1:0] tab_s;

	assign xs_c  = x_q >>> step_q;
	assign ys_c  = y_q >>> step_q;
	assign tab_s = ACC_W'($signed({1'b0, atan_deg(5'(step_q))}));

	// biased angle for the divide by 360
	logic signed [ACC_W:0] v_sum;

	assign v_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(ROUND_BIAS);

	// shared multiplier operand select
	logic [MUL_W-1:0] mul_a;
	logic [MUL_W-1:0] mul_b;

	always_comb begin
		case (state_q)
			ST_SQX: begin
				mul_a = MUL_W'(dx_abs);
				mul_b = MUL_W'(dx_abs);
			end
			ST_SQY: begin
				mul_a = MUL_W'(dy_abs);
				mul_b = MUL_W'(dy_abs);
			end
			ST_RAD: begin
				mul_a = MUL_W'(radius_q);
				mul_b = MUL_W'(radius_q);
			end
			ST_SCALE: begin
				mul_a = MUL_W'(v_sum[V_W-1:0]);
				mul_b = RECIP_360;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// unwrapped heading error and the turn and command decisions
	logic signed [17:0] da_c;
	logic signed [17:0] da_abs;
	logic signed [17:0] tol_s;
	logic               go_right;
	logic               go_left;
	logic               turning;
	logic [1:0]         cmd_c;

	assign da_c     = $signed({2'b00, bearing_q}) - $signed({2'b00, car_q});
	assign da_abs   = da_c[17] ? -da_c : da_c;
	assign tol_s    = $signed({3'b000, tol_q});
	assign go_right = ((da_c > tol_s) && (da_c < HALF_S)) || (da_c < -HALF_S);
	assign go_left  = ((da_c < -tol_s) && (da_c > -HALF_S)) || (da_c > HALF_S);
	assign turning  = (turn_q == TURN_RIGHT) || (turn_q == TURN_LEFT);

	always_comb begin
		if (target_q >= len_c) begin
			cmd_c = CMD_STOP;
		end else if (turning && (da_abs > tol_s)) begin
			cmd_c = (turn_q == TURN_RIGHT) ? CMD_RIGHT : CMD_LEFT;
		end else begin
			cmd_c = CMD_FORWARD;
		end
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= 1'b0;
			step_q     <= '0;
			plen_q     <= 7'd0;
			radius_q   <= 15'd77;
			tol_q      <= 15'd782;
			target_q   <= 7'd0;
			bearing_q  <= 16'd0;
			turn_q     <= TURN_NONE;
			last_cmd_q <= CMD_STOP;
			strobe_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_PATH_LENGTH:     plen_q   <= cfg_data[6:0];
					REG_ARRIVE_RADIUS:   radius_q <= cfg_data;
					REG_ANGLE_TOLERANCE: tol_q    <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (opcode == OP_LOAD) begin
							// a load reports the current status right away
							strobe_q <= 1'b1;
							done_q   <= (target_q >= len_c);
						end else begin
							phase_q <= 1'b0;
							state_q <= (target_q < len_c) ? ST_DIFF : ST_CMD;
						end
					end
				end
				ST_DIFF: begin
					if (!phase_q) begin
						state_q <= ST_SQX;
					end else if (zero_off) begin
						// coincident points have bearing zero
						bearing_q <= 16'd0;
						state_q   <= ST_TURN;
					end else begin
						step_q  <= '0;
						state_q <= ST_ROT;
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_RAD;
				ST_RAD: state_q <= ST_CMP;
				ST_CMP: begin
					// product register holds radius squared here
					if (d2_q < 33'(prod_q[29:0])) begin
						target_q <= target_q + 7'd1;
						if ((target_q + 7'd1) < len_c) begin
							phase_q <= 1'b1;
							state_q <= ST_WAIT;
						end else begin
							state_q <= ST_CMD;
						end
					end else begin
						state_q <= ST_CMD;
					end
				end
				// table read of the new target
				ST_WAIT: state_q <= ST_DIFF;
				ST_ROT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_QUO;
				ST_QUO: begin
					bearing_q <= prod_q[RECIP_SHIFT+15:RECIP_SHIFT];
					state_q   <= ST_TURN;
				end
				ST_TURN: begin
					if (go_right) begin
						turn_q <= TURN_RIGHT;
					end else if (go_left) begin
						turn_q <= TURN_LEFT;
					end else begin
						turn_q <= TURN_NONE;
					end
					state_q <= ST_CMD;
				end
				ST_CMD: begin
					last_cmd_q <= cmd_c;
					// heading inside the dead band ends the pending turn
					if ((target_q < len_c) && turning && !(da_abs > tol_s)) begin
						turn_q <= TURN_NONE;
					end
					strobe_q <= 1'b1;
					done_q   <= (target_q >= len_c);
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			px_q  <= pos_x;
			py_q  <= pos_y;
			car_q <= heading + QUARTER_TURN;
		end
		case (state_q)
			ST_DIFF: begin
				if (!phase_q) begin
					dx_q <= dx_c;
					dy_q <= dy_c;
				end else begin
					x_q   <= x_init;
					y_q   <= y_init;
					acc_q <= acc_init;
				end
			end
			ST_SQY: d2_q <= 33'(prod_q[31:0]);
			ST_RAD: d2_q <= d2_q + 33'(prod_q[31:0]);
			ST_ROT: begin
				if (y_q > 0) begin
					x_q   <= x_q + ys_c;
					y_q   <= y_q - xs_c;
					acc_q <= acc_q + tab_s;
				end else begin
					x_q   <= x_q - ys_c;
					y_q   <= y_q + xs_c;
					acc_q <= acc_q - tab_s;
				end
			end
			default: ;
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign strobe        = strobe_q;
	assign drive_command = last_cmd_q;
	assign done_res      = done_q;
	assign target_index  = target_q;

endmodule

FILE: src/wpf_checker.sv
// port-level checks of the waypoint path follower and their bind
module wpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [1:0]  drive_command,
	input logic [6:0]  target_index
);

	// a taken item either starts work or reports in the next cycle
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || strobe))
		else $error("item taken but neither busy nor result");

	// results are shown only while the block is free
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result shown while busy");

	// the end of a tick always delivers its result
	a_busy_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe)
		else $error("tick ended without a result");

	// status holds while nothing is taken
	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> ($stable(target_index) && $stable(drive_command)))
		else $error("status moved while idle");

endmodule

bind waypoint_path_follower wpf_checker u_wpf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.strobe       (strobe),
	.drive_command(drive_command),
	.target_index (target_index)
);

FILE: dv/tb_waypoint_path_follower.sv
// testbench of the waypoint path follower: directed table, then random phases checked by a predictor
`timescale 1ns / 100ps

module tb_waypoint_path_follower;
	import wpf_pkg::*;

	localparam int     N_SLOTS     = WPF_MAX_WAYPOINTS;
	localparam int     CYCLE_LIMIT = 400000;
	localparam int     N_PHASES    = 9;
	localparam int     PHASE_ITEMS = 115;
	// one full turn in 1/65536 degree
	localparam longint DEG_FULL    = 23592960;

	typedef struct packed {
		logic [1:0] cmd;
		logic       done;
		logic [6:0] target;
	} drive_result_t;

	// one row of the directed table: either a register write or an item
	typedef struct packed {
		logic          is_cfg;
		logic [1:0]    reg_idx;
		logic [14:0]   reg_val;
		logic          op;
		logic [5:0]    slot;
		logic [15:0]   x;
		logic [15:0]   y;
		logic [15:0]   hdg;
		logic          typed;
		drive_result_t want;
	} stim_row_t;

	// dut ports, all known from time zero
	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               start          = 1'b0;
	logic               opcode         = 1'b0;
	logic [5:0]         waypoint_index = '0;
	logic signed [15:0] pos_x          = '0;
	logic signed [15:0] pos_y          = '0;
	logic [15:0]        heading        = '0;
	logic               cfg_we         = 1'b0;
	logic [1:0]         cfg_index      = '0;
	logic [14:0]        cfg_data       = '0;
	logic               busy;
	logic               strobe;
	logic [1:0]         drive_command;
	logic               done_res;
	logic [6:0]         target_index;

	// predicted state of the block
	logic signed [15:0] wp_x [N_SLOTS];
	logic signed [15:0] wp_y [N_SLOTS];
	logic [6:0]         p_target  = '0;
	logic [15:0]        p_bearing = '0;
	logic [1:0]         p_turn    = TURN_NONE;
	logic [1:0]         p_last    = CMD_STOP;
	logic [6:0]         r_path_len = 7'd0;
	logic [14:0]        r_radius   = 15'd77;
	logic [14:0]        r_tol      = 15'd782;

	// atan(2^-i) in degrees times 65536
	longint atan_lut [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	drive_result_t pending_drive [$];
	stim_row_t     dir_rows [$];
	int            mismatch_count = 0;
	int            cycle_count    = 0;

	waypoint_path_follower dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.waypoint_index (waypoint_index),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.heading        (heading),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.strobe         (strobe),
		.drive_command  (drive_command),
		.done_res       (done_res),
		.target_index   (target_index)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// run limit far above the slowest legal run
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(string what, int got, int exp_val);
		mismatch_count++;
		$display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
			what, got, exp_val, cycle_count);
	endtask

	// cordic vectoring on offsets scaled by 256, degrees in 1/65536, rounded to 1/65536 turn
	function automatic logic [15:0] cordic_bearing(longint dx, longint dy);
		longint x, y, xs, ys, acc, q;
		int     i;
		if (dx == 0 && dy == 0) begin
			return 16'd0;
		end
		x   = dx * 256;
		y   = dy * 256;
		acc = 0;
		// left half plane: flip onto the right and add half a turn
		if (x < 0) begin
			x   = -x;
			y   = -y;
			acc = DEG_HALF;
		end
		for (i = 0; i < WPF_CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x   = x + ys;
				y   = y - xs;
				acc = acc + atan_lut[i];
			end else begin
				x   = x - ys;
				y   = y + xs;
				acc = acc - atan_lut[i];
			end
		end
		// bias by two turns so the division never sees a negative value
		acc = acc + 2 * DEG_FULL;
		q   = (acc + 180) / 360;
		return q[15:0];
	endfunction

	// steps the predicted state by one item and returns the result it causes
	function automatic drive_result_t predict_drive(logic op, logic [5:0] slot,
			logic signed [15:0] px, logic signed [15:0] py, logic [15:0] hdg);
		int            len;
		longint        dx, dy, da, tol;
		logic [15:0]   car;
		drive_result_t res;
		// path length above the table saturates
		len = (int'(r_path_len) > N_SLOTS) ? N_SLOTS : int'(r_path_len);
		if (op == OP_LOAD) begin
			wp_x[slot] = px;
			wp_y[slot] = py;
		end else begin
			// body angle is a quarter turn off the bearing frame
			car = hdg + QUARTER_TURN;
			tol = longint'(r_tol);
			if (int'(p_target) < len) begin
				dx = longint'(wp_x[p_target[5:0]]) - longint'(px);
				dy = longint'(wp_y[p_target[5:0]]) - longint'(py);
				// arrival: squared distance strictly inside squared radius
				if (dx * dx + dy * dy < longint'(r_radius) * longint'(r_radius)) begin
					p_target = p_target + 7'd1;
					if (int'(p_target) < len) begin
						dx        = longint'(wp_x[p_target[5:0]]) - longint'(px);
						dy        = longint'(wp_y[p_target[5:0]]) - longint'(py);
						p_bearing = cordic_bearing(dx, dy);
						// unwrapped difference with the exact boundary rules
						da = longint'(p_bearing) - longint'(car);
						if ((da > tol && da < 32768) || da < -32768) begin
							p_turn = TURN_RIGHT;
						end else if ((da < -tol && da > -32768) || da > 32768) begin
							p_turn = TURN_LEFT;
						end else begin
							p_turn = TURN_NONE;
						end
					end
				end
			end
			if (int'(p_target) >= len) begin
				p_last = CMD_STOP;
			end else begin
				p_last = CMD_FORWARD;
				// a pending turn holds until the heading is inside the dead band
				if (p_turn == TURN_RIGHT || p_turn == TURN_LEFT) begin
					da = longint'(p_bearing) - longint'(car);
					if (da < 0) begin
						da = -da;
					end
					if (da > tol) begin
						p_last = (p_turn == TURN_RIGHT) ? CMD_RIGHT : CMD_LEFT;
					end else begin
						p_turn = TURN_NONE;
					end
				end
			end
		end
		res.cmd    = p_last;
		res.done   = (int'(p_target) >= len);
		res.target = p_target;
		return res;
	endfunction

	function automatic stim_row_t item_row(logic op, logic [5:0] slot, int x, int y, int hdg);
		stim_row_t row;
		row      = '0;
		row.op   = op;
		row.slot = slot;
		row.x    = x[15:0];
		row.y    = y[15:0];
		row.hdg  = hdg[15:0];
		return row;
	endfunction

	// item whose result is plain from the spec: stop, finished and a known target
	function automatic stim_row_t typed_row(logic op, logic [5:0] slot, int x, int y, int hdg,
			logic [1:0] cmd, logic done, logic [6:0] tgt);
		stim_row_t row;
		row             = item_row(op, slot, x, y, hdg);
		row.typed       = 1'b1;
		row.want.cmd    = cmd;
		row.want.done   = done;
		row.want.target = tgt;
		return row;
	endfunction

	function automatic stim_row_t reg_row(logic [1:0] idx, int val);
		stim_row_t row;
		row         = '0;
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val[14:0];
		return row;
	endfunction

	// drive one item from a falling edge and hold it until the block takes it
	task automatic send_item(logic op, logic [5:0] slot, logic [15:0] x, logic [15:0] y,
			logic [15:0] hdg, logic typed, drive_result_t typed_res);
		drive_result_t res;
		@(negedge clk);
		start          <= 1'b1;
		opcode         <= op;
		waypoint_index <= slot;
		pos_x          <= x;
		pos_y          <= y;
		heading        <= hdg;
		do @(posedge clk); while (busy !== 1'b0);
		res = predict_drive(op, slot, x, y, hdg);
		pending_drive.push_back(typed ? typed_res : res);
	endtask

	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// sender stands still until every result is back
	task automatic wait_results;
		@(negedge clk);
		start <= 1'b0;
		while (pending_drive.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [14:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PATH_LENGTH:     r_path_len = val[6:0];
			REG_ARRIVE_RADIUS:   r_radius   = val;
			REG_ANGLE_TOLERANCE: r_tol      = val;
			default: ;
		endcase
	endtask

	// result checker: every strobe must match the oldest prediction
	always @(posedge clk) begin : result_check
		drive_result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (pending_drive.size() == 0) begin
				report_mismatch("unexpected result", int'(target_index), -1);
			end else begin
				want = pending_drive.pop_front();
				if (drive_command !== want.cmd) begin
					report_mismatch("drive_command", int'(drive_command), int'(want.cmd));
				end
				if (done_res !== want.done) begin
					report_mismatch("done_res", int'(done_res), int'(want.done));
				end
				if (target_index !== want.target) begin
					report_mismatch("target_index", int'(target_index), int'(want.target));
				end
			end
		end
	end

	initial begin : stimulus
		int            i, ph, k, kind, r, d, t, off, gap;
		int            bx, by, vx, vy, hd;
		int            ph_len, ph_rad, ph_tol;
		bit            burst;
		stim_row_t     row;
		drive_result_t no_check;
		logic [5:0]    slot;

		no_check = '0;
		burst    = 1'b0;

		// ticks with nothing to follow, then loads; all answered with stop and finished
		dir_rows.push_back(typed_row(OP_TICK, 0, 0, 0, 0, CMD_STOP, 1'b1, 7'd0));
		dir_rows.push_back(typed_row(OP_TICK, 63, -32768, 32767, 65535, CMD_STOP, 1'b1, 7'd0));
		dir_rows.push_back(typed_row(OP_LOAD, 0, 0, 0, 0, CMD_STOP, 1'b1, 7'd0));
		dir_rows.push_back(typed_row(OP_LOAD, 1, 32767, -32768, 0, CMD_STOP, 1'b1, 7'd0));
		dir_rows.push_back(typed_row(OP_LOAD, 2, -32768, 32767, 0, CMD_STOP, 1'b1, 7'd0));
		// ten units past slot 2 in x, so arriving there from slot 3 leaves a zero offset
		dir_rows.push_back(typed_row(OP_LOAD, 3, -32758, 32767, 0, CMD_STOP, 1'b1, 7'd0));
		dir_rows.push_back(typed_row(OP_LOAD, 4, 1000, 1000, 0, CMD_STOP, 1'b1, 7'd0));
		dir_rows.push_back(typed_row(OP_LOAD, 63, -1, -1, 65535, CMD_STOP, 1'b1, 7'd0));
		dir_rows.push_back(reg_row(REG_PATH_LENGTH, 4));
		// arrival at slot 0, bearing toward the far corner
		dir_rows.push_back(item_row(OP_TICK, 0, 0, 0, 0));
		dir_rows.push_back(item_row(OP_TICK, 0, 5000, -5000, 16'hc000));
		// arrival at slot 1, largest offsets to slot 2
		dir_rows.push_back(item_row(OP_TICK, 0, 32767, -32768, 16'h4000));
		// arrival at slot 2 with the vehicle exactly on slot 3
		dir_rows.push_back(item_row(OP_TICK, 0, -32758, 32767, 16'h8000));
		dir_rows.push_back(typed_row(OP_TICK, 0, -32758, 32767, 0, CMD_STOP, 1'b1, 7'd4));
		// path shortened below the target
		dir_rows.push_back(reg_row(REG_PATH_LENGTH, 2));
		dir_rows.push_back(typed_row(OP_TICK, 0, 0, 0, 0, CMD_STOP, 1'b1, 7'd4));
		dir_rows.push_back(typed_row(OP_LOAD, 5, 2000, -3000, 0, CMD_STOP, 1'b1, 7'd4));
		// length above the table saturates
		dir_rows.push_back(reg_row(REG_PATH_LENGTH, 127));
		dir_rows.push_back(item_row(OP_TICK, 0, -20000, -20000, 16'h1234));
		dir_rows.push_back(item_row(OP_TICK, 0, 1010, 990, 16'hfff0));
		// zero radius: sitting on the target is not arrival
		dir_rows.push_back(reg_row(REG_ARRIVE_RADIUS, 0));
		dir_rows.push_back(item_row(OP_TICK, 0, 2000, -3000, 16'h0001));
		dir_rows.push_back(reg_row(REG_ANGLE_TOLERANCE, 0));
		dir_rows.push_back(item_row(OP_TICK, 0, 0, 0, 16'h8000));
		dir_rows.push_back(reg_row(REG_ANGLE_TOLERANCE, 32767));
		dir_rows.push_back(item_row(OP_TICK, 0, -32768, -32768, 16'h7fff));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < dir_rows.size(); k++) begin
			row = dir_rows[k];
			if (row.is_cfg) begin
				wait_results;
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				send_item(row.op, row.slot, row.x, row.y, row.hdg, row.typed, row.want);
				hold_off($urandom_range(0, 7));
			end
		end

		// fill the whole table before any tick can read past what is written
		for (i = 0; i < N_SLOTS; i++) begin
			slot = 6'(i);
			send_item(OP_LOAD, slot, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0,
				no_check);
			hold_off($urandom_range(0, 3));
		end

		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0:       begin ph_len = 64;  ph_rad = 77;    ph_tol = 782;   end
				1:       begin ph_len = 64;  ph_rad = 0;     ph_tol = 0;     end
				2:       begin ph_len = 64;  ph_rad = 300;   ph_tol = 100;   end
				3:       begin ph_len = 127; ph_rad = 2000;  ph_tol = 16384; end
				4:       begin ph_len = 2;   ph_rad = 77;    ph_tol = 782;   end
				5:       begin ph_len = 64;  ph_rad = 1;     ph_tol = 32767; end
				6:       begin ph_len = 0;   ph_rad = 500;   ph_tol = 3000;  end
				7:       begin ph_len = 64;  ph_rad = 600;   ph_tol = 0;     end
				default: begin ph_len = 100; ph_rad = 32767; ph_tol = 32767; end
			endcase
			// registers change only with the block idle
			wait_results;
			write_reg(REG_PATH_LENGTH, 15'(ph_len));
			write_reg(REG_ARRIVE_RADIUS, 15'(ph_rad));
			write_reg(REG_ANGLE_TOLERANCE, 15'(ph_tol));
			burst = 1'($urandom_range(0, 1));

			for (i = 0; i < PHASE_ITEMS; i++) begin
				// switch between back-to-back stretches and gapped ones
				if ($urandom_range(0, 39) == 0) begin
					burst = !burst;
				end
				if ($urandom_range(0, 99) == 0) begin
					wait_results;
				end
				r = $urandom_range(0, 99);
				if (r < 15) begin
					// reload a slot, sometimes with corner values
					if (r < 4) begin
						case ($urandom_range(0, 3))
							0:       vx = -32768;
							1:       vx = 32767;
							2:       vx = 0;
							default: vx = -1;
						endcase
						vy = (r < 2) ? -vx - 1 : vx;
					end else begin
						vx = $urandom;
						vy = $urandom;
					end
					send_item(OP_LOAD, 6'($urandom), vx[15:0], vy[15:0], 16'($urandom), 1'b0,
						no_check);
				end else begin
					if (int'(p_target) < N_SLOTS) begin
						bx = wp_x[p_target[5:0]];
						by = wp_y[p_target[5:0]];
					end else begin
						bx = 0;
						by = 0;
					end
					kind = $urandom_range(0, 99);
					if (kind < 6) begin
						// close in on the target, well inside the radius
						off = int'(r_radius) / 2;
						vx  = bx + int'($urandom_range(0, 2 * off)) - off;
						vy  = by + int'($urandom_range(0, 2 * off)) - off;
					end else if (kind < 18) begin
						// right on the radius, one axis only
						d = int'($urandom_range(0, 4)) - 2;
						if ($urandom_range(0, 1)) begin
							vx = bx - (int'(r_radius) + d);
							vy = by;
						end else begin
							vx = bx;
							vy = by + (int'(r_radius) + d);
						end
					end else if (kind < 50 && r_radius < 8192) begin
						vx = int'($urandom_range(0, 65535)) - 32768;
						vy = int'($urandom_range(0, 65535)) - 32768;
					end else begin
						// opposite corner: never arrives even with the largest radius
						vx = (bx >= 0) ? -32768 + int'($urandom_range(0, 255))
							: 32767 - int'($urandom_range(0, 255));
						vy = (by >= 0) ? -32768 + int'($urandom_range(0, 255))
							: 32767 - int'($urandom_range(0, 255));
					end
					// heading: random, or aimed around the bearing to probe the dead band
					t = int'(r_tol);
					case ($urandom_range(0, 3))
						0: hd = $urandom;
						1: hd = int'(p_bearing) - 16384 + int'($urandom_range(0, 2 * t + 6)) - t - 3;
						2: hd = int'(p_bearing) - 16384 + ($urandom_range(0, 1) ? t : -t)
							+ int'($urandom_range(0, 2)) - 1;
						default: hd = int'(p_bearing) + 16384 + int'($urandom_range(0, 6)) - 3;
					endcase
					send_item(OP_TICK, 6'($urandom), vx[15:0], vy[15:0], hd[15:0], 1'b0,
						no_check);
				end
				gap = burst ? 0 : $urandom_range(0, 7);
				hold_off(gap);
			end
		end

		// drain, then let the pipeline settle
		wait_results;
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_drive.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
